>>> sv/hrat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the host register allocation table.
// No dependencies.

package hrat_pkg;

	localparam int NUM_HOST_REGS_DEF = 32;
	localparam int AGE_W = 32;
	localparam int MASK_W = 32;
	localparam logic [MASK_W-1:0] RESERVED_RESET = 32'h3003_0000;

	localparam int MODE_WR_BIT = 1;
	localparam int MODE_CS_BIT = 2;

	typedef enum logic [3:0] {
		CMD_ALLOC        = 4'd0,
		CMD_CHECK        = 4'd1,
		CMD_HAS          = 4'd2,
		CMD_ADD_NEEDED   = 4'd3,
		CMD_CLEAR_NEEDED = 4'd4,
		CMD_FREE         = 4'd5,
		CMD_FREE_NOWB    = 4'd6,
		CMD_FREE_ALL     = 4'd7,
		CMD_WRITEBACK    = 4'd8,
		CMD_FLUSH        = 4'd9,
		CMD_CLEAR        = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_ANS
	} state_t;

	typedef struct packed {
		logic [2:0] rtype;
		logic [6:0] guest;
		logic [7:0] emode;
	} meta_t;

	typedef struct packed {
		logic             valid;
		logic             age_set;
		logic [AGE_W-1:0] best_age;
		logic [2:0]       rtype;
		logic [6:0]       guest;
		logic [7:0]       mode;
	} cmp_req_t;

	typedef struct packed {
		logic             match;
		logic             has_hit;
		logic             age_less;
		logic             wr;
		logic             cs;
		logic [AGE_W-1:0] age_eff;
	} cmp_t;

endpackage

>>> sv/hrat_mem.sv
`timescale 1ns / 1ps
// Entry storage: class, guest index and mode bits, plus age stamps.
// One write port, one registered read port. Depends on hrat_pkg.

module hrat_mem import hrat_pkg::*; #(
	parameter int NUM_HOST_REGS = NUM_HOST_REGS_DEF
) (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [$clog2(NUM_HOST_REGS)-1:0] rd_addr,
	output meta_t                            rd_meta,
	output logic [AGE_W-1:0]                 rd_age,
	input  logic                             wr_meta_en,
	input  logic                             wr_age_en,
	input  logic [$clog2(NUM_HOST_REGS)-1:0] wr_addr,
	input  meta_t                            wr_meta,
	input  logic [AGE_W-1:0]                 wr_age
);

	meta_t            meta_mem [NUM_HOST_REGS];
	logic [AGE_W-1:0] age_mem  [NUM_HOST_REGS];

	always_ff @(posedge clk) begin
		if (wr_meta_en) begin
			meta_mem[wr_addr] <= wr_meta;
		end
		if (wr_age_en) begin
			age_mem[wr_addr] <= wr_age;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_meta <= meta_mem[rd_addr];
			rd_age  <= age_mem[rd_addr];
		end
	end

endmodule

>>> sv/hrat_cmp.sv
`timescale 1ns / 1ps
// Shared compare unit: tag match, mode overlap and age compare for one entry.
// Depends on hrat_pkg.

module hrat_cmp import hrat_pkg::*; (
	input  cmp_req_t         req,
	input  meta_t            meta,
	input  logic [AGE_W-1:0] age,
	output cmp_t             res
);

	always_comb begin
		res.match    = req.valid && (meta.rtype == req.rtype) && (meta.guest == req.guest);
		res.has_hit  = res.match && ((req.mode == 8'd0) || ((meta.emode & req.mode) != 8'd0));
		res.age_eff  = req.age_set ? age : '0;
		res.age_less = res.age_eff < req.best_age;
		res.wr       = meta.emode[MODE_WR_BIT];
		res.cs       = meta.emode[MODE_CS_BIT];
	end

endmodule

>>> sv/hrat_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: entry scan, allocation choice, writeback and answer.
// Depends on hrat_pkg; drives hrat_mem and hrat_cmp.

module hrat_ctrl import hrat_pkg::*; #(
	parameter int NUM_HOST_REGS = NUM_HOST_REGS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [3:0]                       cmd,
	input  logic [4:0]                       host_reg,
	input  logic [2:0]                       reg_type,
	input  logic [6:0]                       guest_reg,
	input  logic [7:0]                       mode,
	input  logic [MASK_W-1:0]                reserved_mask,
	output logic                             result_strobe,
	output logic                             kind,
	output logic [4:0]                       result_reg,
	output logic                             ok,
	output logic [2:0]                       wb_type,
	output logic [6:0]                       wb_reg,
	output logic                             last,
	output logic                             rd_en,
	output logic [$clog2(NUM_HOST_REGS)-1:0] rd_addr,
	input  meta_t                            rd_meta,
	output logic                             wr_meta_en,
	output logic                             wr_age_en,
	output logic [$clog2(NUM_HOST_REGS)-1:0] wr_addr,
	output meta_t                            wr_meta,
	output logic [AGE_W-1:0]                 wr_age,
	output cmp_req_t                         creq,
	input  cmp_t                             cres
);

	localparam int IDX_W = $clog2(NUM_HOST_REGS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_HOST_REGS - 1);

	state_t state_q, state_d;
	cmd_t   cmd_in, cmd_q;

	logic [2:0]             t_q;
	logic [6:0]             g_q;
	logic [7:0]             m_q;
	logic [IDX_W-1:0]       addr_q, hi_q, idx_s1;
	logic                   issue_q, rd_s1;
	logic [NUM_HOST_REGS-1:0] valid_q, needed_q, aset_q;
	logic [AGE_W-1:0]       age_clock_q, best_age_q;
	logic                   found_q, has_found_q, free_found_q, ev_found_q;
	logic [IDX_W-1:0]       hit_idx_q, has_idx_q, free_idx_q, ev_idx_q;
	logic [7:0]             hit_mode_q;
	meta_t                  ev_meta_q;
	logic                   ans_ok_q;
	logic [4:0]             ans_reg_q;

	logic             accept, hr_ok, scan_go, single;
	logic             rsv, proc_act, proc_wb, proc_rel, emit_wb, fill;
	logic [IDX_W-1:0] wb_idx, fill_idx;
	meta_t            wb_meta;
	logic [7:0]       upd_mode;

	assign cmd_in = cmd_t'(cmd);
	assign accept = (state_q == ST_IDLE) && start;
	assign busy   = (state_q != ST_IDLE);
	assign hr_ok  = 32'(host_reg) < NUM_HOST_REGS;
	assign rsv    = (32'(idx_s1) < MASK_W) && reserved_mask[5'(idx_s1)];
	assign fill_idx = free_found_q ? free_idx_q : ev_idx_q;
	assign upd_mode = ((m_q != 8'd0) && ((hit_mode_q & m_q) == 8'd0)) ?
		(hit_mode_q | m_q) : hit_mode_q;

	assign rd_en   = (state_q == ST_SCAN) && issue_q;
	assign rd_addr = addr_q;

	assign creq.valid    = valid_q[idx_s1];
	assign creq.age_set  = aset_q[idx_s1];
	assign creq.best_age = best_age_q;
	assign creq.rtype    = t_q;
	assign creq.guest    = g_q;
	assign creq.mode     = m_q;

	always_comb begin
		scan_go = 1'b0;
		single  = 1'b0;
		case (cmd_in)
			CMD_ALLOC, CMD_CHECK, CMD_HAS, CMD_ADD_NEEDED, CMD_FREE_ALL, CMD_FLUSH: begin
				scan_go = 1'b1;
			end
			CMD_FREE, CMD_FREE_NOWB, CMD_WRITEBACK: begin
				scan_go = hr_ok;
				single  = 1'b1;
			end
			default: begin
				scan_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		wr_meta_en = 1'b0;
		wr_age_en  = 1'b0;
		wr_addr    = idx_s1;
		wr_meta    = rd_meta;
		wr_age     = age_clock_q + AGE_W'(1);
		emit_wb    = 1'b0;
		wb_idx     = idx_s1;
		wb_meta    = rd_meta;
		fill       = 1'b0;
		proc_act   = 1'b0;
		proc_wb    = 1'b0;
		proc_rel   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = scan_go ? ST_SCAN : ST_ANS;
				end
			end
			ST_SCAN: begin
				if (rd_s1) begin
					proc_act = valid_q[idx_s1] && ((cmd_q == CMD_FREE_ALL) ||
						(cmd_q == CMD_FREE) || (cmd_q == CMD_FREE_NOWB) ||
						(cmd_q == CMD_WRITEBACK) ||
						((cmd_q == CMD_FLUSH) && !needed_q[idx_s1]));
					proc_wb  = proc_act && (cmd_q != CMD_FREE_NOWB) && cres.wr;
					proc_rel = proc_act && (cmd_q != CMD_WRITEBACK);
					if (proc_wb) begin
						wr_meta_en = 1'b1;
						wr_meta.emode[MODE_WR_BIT] = 1'b0;
						emit_wb = 1'b1;
					end
					if (!issue_q) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				state_d = ST_ANS;
				if ((cmd_q == CMD_ALLOC) || (cmd_q == CMD_CHECK)) begin
					if (found_q) begin
						wr_meta_en = 1'b1;
						wr_addr    = hit_idx_q;
						wr_meta    = '{rtype: t_q, guest: g_q, emode: upd_mode};
					end else if ((cmd_q == CMD_ALLOC) && (free_found_q || ev_found_q)) begin
						fill       = 1'b1;
						wr_meta_en = 1'b1;
						wr_age_en  = 1'b1;
						wr_addr    = fill_idx;
						wr_meta    = '{rtype: t_q, guest: g_q, emode: m_q};
						if (!free_found_q && ev_meta_q.emode[MODE_WR_BIT]) begin
							emit_wb = 1'b1;
							wb_idx  = ev_idx_q;
							wb_meta = ev_meta_q;
						end
					end
				end
			end
			ST_ANS: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer datapath and table flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= 1'b0;
			rd_s1       <= 1'b0;
			valid_q     <= '0;
			needed_q    <= '0;
			aset_q      <= '0;
			age_clock_q <= '0;
		end else begin
			rd_s1 <= rd_en;
			if (rd_en) begin
				idx_s1 <= addr_q;
				if (addr_q == hi_q) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + IDX_W'(1);
				end
			end

			if (accept) begin
				cmd_q        <= cmd_in;
				t_q          <= reg_type;
				g_q          <= guest_reg;
				m_q          <= mode;
				addr_q       <= single ? IDX_W'(host_reg) : '0;
				hi_q         <= single ? IDX_W'(host_reg) : LAST_IDX;
				issue_q      <= scan_go;
				found_q      <= 1'b0;
				has_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				ev_found_q   <= 1'b0;
				ans_ok_q     <= 1'b0;
				ans_reg_q    <= single ? host_reg : 5'd0;
				case (cmd_in)
					CMD_CLEAR_NEEDED: begin
						needed_q <= '0;
						ans_ok_q <= 1'b1;
					end
					CMD_CLEAR: begin
						valid_q     <= '0;
						needed_q    <= '0;
						aset_q      <= '0;
						age_clock_q <= '0;
						ans_ok_q    <= 1'b1;
					end
					CMD_FREE_ALL, CMD_FLUSH: begin
						ans_ok_q <= 1'b1;
					end
					default: begin
						ans_ok_q <= 1'b0;
					end
				endcase
			end

			if ((state_q == ST_SCAN) && rd_s1) begin
				if (cres.match && !found_q) begin
					found_q    <= 1'b1;
					hit_idx_q  <= idx_s1;
					hit_mode_q <= rd_meta.emode;
				end
				if (cres.has_hit && !has_found_q) begin
					has_found_q <= 1'b1;
					has_idx_q   <= idx_s1;
				end
				if (!rsv && !valid_q[idx_s1] && (!free_found_q || cres.age_less)) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
					best_age_q   <= cres.age_eff;
				end
				if (!rsv && valid_q[idx_s1] && !cres.cs && !ev_found_q) begin
					ev_found_q <= 1'b1;
					ev_idx_q   <= idx_s1;
					ev_meta_q  <= rd_meta;
				end
				if (proc_act && ((cmd_q != CMD_WRITEBACK) || proc_wb)) begin
					ans_ok_q <= 1'b1;
				end
				if (proc_rel) begin
					valid_q[idx_s1]  <= 1'b0;
					needed_q[idx_s1] <= 1'b0;
				end
			end

			if (state_q == ST_FINISH) begin
				case (cmd_q)
					CMD_ALLOC, CMD_CHECK, CMD_ADD_NEEDED: begin
						if (found_q) begin
							needed_q[hit_idx_q] <= 1'b1;
							ans_ok_q  <= 1'b1;
							ans_reg_q <= 5'(hit_idx_q);
						end else if (fill) begin
							valid_q[fill_idx]  <= 1'b1;
							needed_q[fill_idx] <= 1'b1;
							aset_q[fill_idx]   <= 1'b1;
							age_clock_q        <= age_clock_q + AGE_W'(1);
							ans_ok_q  <= 1'b1;
							ans_reg_q <= 5'(fill_idx);
						end
					end
					CMD_HAS: begin
						if (has_found_q) begin
							ans_ok_q  <= 1'b1;
							ans_reg_q <= 5'(has_idx_q);
						end
					end
					default: begin
						ans_ok_q <= ans_ok_q;
					end
				endcase
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit_wb || (state_q == ST_ANS);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_wb) begin
			kind       <= 1'b1;
			result_reg <= 5'(wb_idx);
			ok         <= 1'b1;
			wb_type    <= wb_meta.rtype;
			wb_reg     <= wb_meta.guest;
			last       <= 1'b0;
		end else begin
			kind       <= 1'b0;
			result_reg <= ans_reg_q;
			ok         <= ans_ok_q;
			wb_type    <= 3'd0;
			wb_reg     <= 7'd0;
			last       <= 1'b1;
		end
	end

endmodule

>>> sv/host_register_alloc_table_top.sv
`timescale 1ns / 1ps
// Top level of the host register allocation table.
// Depends on hrat_pkg, hrat_mem, hrat_cmp and hrat_ctrl.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------------------------
//   config    | cfg_wr_en                  | cfg_wr_data (reserved_mask)
//   command   | start, busy                | cmd, host_reg, reg_type, guest_reg, mode
//   result    | result_strobe (no stall)   | kind, result_reg, ok, wb_type, wb_reg, last
//
// Check, alloc, has, add_needed, free_all and flush scan the entry memory one
// entry per cycle through the compare unit, from entry 0 to the last entry.
// free, free_nowb and writeback read only the entry at host_reg; other commands skip the scan.
// Writebacks leave at most one per cycle; the answer comes last, after busy drops.
// Reset clears the table flags, age clock and result strobe; no clearing pass.
// Results are held for one cycle only; the receiver must take them.

module host_register_alloc_table_top import hrat_pkg::*; #(
	parameter int NUM_HOST_REGS = NUM_HOST_REGS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MASK_W-1:0] cfg_wr_data,
	input  logic              start,
	output logic              busy,
	input  logic [3:0]        cmd,
	input  logic [4:0]        host_reg,
	input  logic [2:0]        reg_type,
	input  logic [6:0]        guest_reg,
	input  logic [7:0]        mode,
	output logic              result_strobe,
	output logic              kind,
	output logic [4:0]        result_reg,
	output logic              ok,
	output logic [2:0]        wb_type,
	output logic [6:0]        wb_reg,
	output logic              last
);

	localparam int IDX_W = $clog2(NUM_HOST_REGS);

	logic [MASK_W-1:0] reserved_mask_q;
	logic              rd_en, wr_meta_en, wr_age_en;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	meta_t             rd_meta, wr_meta;
	logic [AGE_W-1:0]  rd_age, wr_age;
	cmp_req_t          creq;
	cmp_t              cres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_mask_q <= RESERVED_RESET;
		end else if (cfg_wr_en) begin
			reserved_mask_q <= cfg_wr_data;
		end
	end

	hrat_mem #(
		.NUM_HOST_REGS(NUM_HOST_REGS)
	) u_mem (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_meta    (rd_meta),
		.rd_age     (rd_age),
		.wr_meta_en (wr_meta_en),
		.wr_age_en  (wr_age_en),
		.wr_addr    (wr_addr),
		.wr_meta    (wr_meta),
		.wr_age     (wr_age)
	);

	hrat_cmp u_cmp (
		.req  (creq),
		.meta (rd_meta),
		.age  (rd_age),
		.res  (cres)
	);

	hrat_ctrl #(
		.NUM_HOST_REGS(NUM_HOST_REGS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.host_reg      (host_reg),
		.reg_type      (reg_type),
		.guest_reg     (guest_reg),
		.mode          (mode),
		.reserved_mask (reserved_mask_q),
		.result_strobe (result_strobe),
		.kind          (kind),
		.result_reg    (result_reg),
		.ok            (ok),
		.wb_type       (wb_type),
		.wb_reg        (wb_reg),
		.last          (last),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_meta       (rd_meta),
		.wr_meta_en    (wr_meta_en),
		.wr_age_en     (wr_age_en),
		.wr_addr       (wr_addr),
		.wr_meta       (wr_meta),
		.wr_age        (wr_age),
		.creq          (creq),
		.cres          (cres)
	);

endmodule
